FILE: hw/rtl/sfp_pkg.sv
// Package with the shared types and constants of the sample frame packer.
package sfp_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned SettleW = 14;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned NumCh   = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 14;

  localparam logic [CfgIdxW-1:0] CFG_IDX_ENABLE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SETTLE    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDX_THRESHOLD = 2'd2;

  localparam logic [SettleW-1:0] SETTLE_RESET    = 14'd15000;
  localparam logic [SampleW-1:0] THRESHOLD_RESET = 10'd100;

  localparam logic [ModeW-1:0] MODE_DEFAULT     = 3'd0;
  localparam logic [ModeW-1:0] MODE_BNC         = 3'd1;
  localparam logic [ModeW-1:0] MODE_FIVE_DIG    = 3'd2;
  localparam logic [ModeW-1:0] MODE_ARDUINO     = 3'd3;
  localparam logic [ModeW-1:0] MODE_MORE_ANALOG = 3'd4;

  localparam logic [SampleW-1:0] BAND_1 = 10'd155;
  localparam logic [SampleW-1:0] BAND_2 = 10'd310;
  localparam logic [SampleW-1:0] BAND_3 = 10'd465;
  localparam logic [SampleW-1:0] BAND_4 = 10'd620;
  localparam logic [SampleW-1:0] BAND_5 = 10'd775;

  localparam logic [SampleW-1:0] MID_CODE   = 10'd512;
  localparam logic [SampleW-1:0] SAMPLE_MAX = 10'd1023;

  localparam logic [2:0] LAST_IDX_STATUS = 3'd0;
  localparam logic [2:0] LAST_IDX_TWO    = 3'd3;
  localparam logic [2:0] LAST_IDX_FOUR   = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0] sample_a;
    logic [SampleW-1:0] sample_b;
    logic [SampleW-1:0] sample_c;
    logic [SampleW-1:0] sample_d;
    logic [SampleW-1:0] mid_reference;
    logic [SampleW-1:0] detect_level;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             frame_last;
    logic [ModeW-1:0] board_mode;
    logic             mode_changed;
  } out_t;

  typedef struct packed {
    logic                          enable;
    logic [2:0]                    last_idx;
    logic [ModeW-1:0]              mode;
    logic                          changed;
    logic [NumCh-1:0][SampleW-1:0] smp;
  } frame_t;

endpackage

FILE: hw/rtl/sfp_tick_calc.sv
// Per-tick logic: settle timer, mode banding and offset correction of the samples.
module sfp_tick_calc (
  input  sfp_pkg::in_t                  in_i,
  input  logic                          enable_i,
  input  logic [sfp_pkg::SettleW-1:0]   settle_ticks_i,
  input  logic [sfp_pkg::SampleW-1:0]   threshold_i,
  input  logic [sfp_pkg::ModeW-1:0]     mode_i,
  input  logic [sfp_pkg::SampleW-1:0]   prev_detect_i,
  input  logic [sfp_pkg::SettleW-1:0]   settle_i,
  output logic [sfp_pkg::SettleW-1:0]   settle_o,
  output sfp_pkg::frame_t               frame_o
);
  import sfp_pkg::*;

  logic [SampleW-1:0] level;
  logic [SampleW-1:0] diff;
  logic [ModeW-1:0]   band;
  logic [ModeW-1:0]   mode_new;
  logic [NumCh-1:0][SampleW-1:0] raw;
  logic [NumCh-1:0][SampleW-1:0] corr;

  assign level = in_i.detect_level;
  assign diff  = (level > prev_detect_i) ? level - prev_detect_i : prev_detect_i - level;

  always_comb begin
    if (settle_i != '0) begin
      settle_o = settle_i - SettleW'(1);
    end else if (diff > threshold_i) begin
      settle_o = settle_ticks_i;
    end else begin
      settle_o = settle_i;
    end
  end

  always_comb begin
    if (level < BAND_1) begin
      band = MODE_DEFAULT;
    end else if (level < BAND_2) begin
      band = MODE_MORE_ANALOG;
    end else if (level < BAND_3) begin
      band = MODE_BNC;
    end else if (level < BAND_4) begin
      band = MODE_FIVE_DIG;
    end else if (level < BAND_5) begin
      band = MODE_ARDUINO;
    end else begin
      band = mode_i;
    end
  end

  assign mode_new = (settle_o == '0) ? band : mode_i;

  assign raw = {in_i.sample_d, in_i.sample_c, in_i.sample_b, in_i.sample_a};

  always_comb begin
    logic signed [SampleW+1:0] v;
    for (int i = 0; i < NumCh; i++) begin
      v = $signed({2'b00, raw[i]}) + $signed({2'b00, MID_CODE})
          - $signed({2'b00, in_i.mid_reference});
      if (v < 0) begin
        corr[i] = '0;
      end else if (v > $signed({2'b00, SAMPLE_MAX})) begin
        corr[i] = SAMPLE_MAX;
      end else begin
        corr[i] = v[SampleW-1:0];
      end
    end
  end

  always_comb begin
    frame_o.enable  = enable_i;
    frame_o.mode    = mode_new;
    frame_o.changed = (mode_new != mode_i);
    frame_o.smp     = corr;
    if (!enable_i) begin
      frame_o.last_idx = LAST_IDX_STATUS;
    end else if (mode_new == MODE_MORE_ANALOG) begin
      frame_o.last_idx = LAST_IDX_FOUR;
    end else begin
      frame_o.last_idx = LAST_IDX_TWO;
    end
  end

endmodule

FILE: hw/rtl/sample_frame_packer_with_board_detect_core.sv
// Top level of the sample frame packer with board detect.
//
//   channel   signals                         transfer when
//   input     in_valid_i/in_ready_o/in_data_i  in_valid_i && in_ready_o
//   output    out_valid_o/out_ready_i/out_data_o  out_valid_o && out_ready_i
//   config    cfg_we_i/cfg_idx_i/cfg_wdata_i    cfg_we_i
//
// A tick is processed in the cycle it is accepted and lands in the frame register.
// Unless stalled, the frame leaves one result per cycle: 1, 4 or 8 per tick.
// The next tick is accepted in the cycle the last result of the frame is taken.
// A stalled output holds the frame register and blocks input.
// Reset clears the mode, detect history, settle timer and loads register defaults.
module sample_frame_packer_with_board_detect_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sfp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  sfp_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output sfp_pkg::out_t                 out_data_o
);
  import sfp_pkg::*;

  logic               enable_q;
  logic [SettleW-1:0] settle_ticks_q;
  logic [SampleW-1:0] threshold_q;
  logic [ModeW-1:0]   mode_q;
  logic [SampleW-1:0] prev_detect_q;
  logic [SettleW-1:0] settle_q;
  logic [SettleW-1:0] settle_d;
  logic               out_valid_q;
  logic [2:0]         idx_q;
  frame_t             frame_q;
  frame_t             frame_d;
  logic               in_fire;
  logic               out_fire;
  logic               frame_done;
  logic [SampleW-1:0] cur;

  sfp_tick_calc u_calc (
    .in_i           (in_data_i),
    .enable_i       (enable_q),
    .settle_ticks_i (settle_ticks_q),
    .threshold_i    (threshold_q),
    .mode_i         (mode_q),
    .prev_detect_i  (prev_detect_q),
    .settle_i       (settle_q),
    .settle_o       (settle_d),
    .frame_o        (frame_d)
  );

  assign out_fire   = out_valid_q && out_ready_i;
  assign frame_done = out_fire && (idx_q == frame_q.last_idx);
  assign in_ready_o = !out_valid_q || frame_done;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      settle_ticks_q <= SETTLE_RESET;
      threshold_q    <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_ENABLE:    enable_q       <= cfg_wdata_i[0];
        CFG_IDX_SETTLE:    settle_ticks_q <= cfg_wdata_i[SettleW-1:0];
        CFG_IDX_THRESHOLD: threshold_q    <= cfg_wdata_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_DEFAULT;
      prev_detect_q <= '0;
      settle_q      <= '0;
      out_valid_q   <= 1'b0;
      idx_q         <= '0;
    end else begin
      if (in_fire) begin
        mode_q        <= frame_d.mode;
        prev_detect_q <= in_data_i.detect_level;
        settle_q      <= settle_d;
        out_valid_q   <= 1'b1;
        idx_q         <= '0;
      end else if (frame_done) begin
        out_valid_q <= 1'b0;
      end else if (out_fire) begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      frame_q <= frame_d;
    end
  end

  assign cur = frame_q.smp[idx_q[2:1]];

  always_comb begin
    out_data_o.byte_valid   = frame_q.enable;
    out_data_o.frame_last   = (idx_q == frame_q.last_idx);
    out_data_o.board_mode   = frame_q.mode;
    out_data_o.mode_changed = frame_q.changed;
    if (!frame_q.enable) begin
      out_data_o.out_byte = '0;
    end else if (idx_q[0]) begin
      out_data_o.out_byte = {1'b0, cur[6:0]};
    end else begin
      out_data_o.out_byte = {(idx_q == 3'd0), 4'b0000, cur[9:7]};
    end
  end

  assign out_valid_o = out_valid_q;

  a_idx_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (idx_q <= frame_q.last_idx))
    else $error("result index beyond end of frame");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while frame is stalled");

  a_status_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !frame_q.enable) |-> (frame_q.last_idx == LAST_IDX_STATUS))
    else $error("status frame with more than one result");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q <= MODE_MORE_ANALOG)
    else $error("board mode out of range");

endmodule
